@@ rtl/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// md5 package
// types, constants and round tables shared by the md5 digest block
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned BLK_AW = $clog2(BLOCK_BYTES);
    localparam int unsigned WORD_W = 32;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [BLK_AW-1:0] LEN_POS = 6'd56;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic       done;
        logic [5:0] round;
    } t_core_ctl;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
            4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
            4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
            4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(5 * r[3:0] + 1);
            2'd2: g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction

endpackage

@@ rtl/md5_ram.sv @@
// ----------------------------------------------------------------------------
// md5 ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ rtl/md5_core.sv @@
// ----------------------------------------------------------------------------
// md5 round core
// one md5 round per cycle on a shared adder and rotator, chain update at end
// ----------------------------------------------------------------------------
module md5_core import md5_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_ctl   i_ctl,
    input  logic        i_reinit,
    input  logic [31:0] i_w,
    output logic [31:0] o_chain [4]
);
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_h [4];
    logic [31:0] f, sum, rot;
    logic [4:0]  s;

    always_comb begin
        case (i_ctl.round[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + round_k(i_ctl.round) + i_w;
        s = round_s(i_ctl.round);
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_reinit) begin
            r_h[0] <= IV_A;
            r_h[1] <= IV_B;
            r_h[2] <= IV_C;
            r_h[3] <= IV_D;
        end else if (i_ctl.done) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
        end
        if (i_ctl.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
        end else if (!i_ctl.done) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
    end

    assign o_chain = r_h;
endmodule

@@ rtl/md5_message_digest_top.sv @@
// ----------------------------------------------------------------------------
// md5 message digest
// byte stream md5 with padding, iterative compression and digest output
// ----------------------------------------------------------------------------
// channel  valid    stall    payload
// in       i_valid  o_stall  i_data_byte i_byte_valid i_end_of_message
// out      o_valid  i_stall  o_digest_word o_word_index o_last_word
//
// a byte that does not fill the block is written to the ram without leaving idle
// a full block goes through word loading, the 64 rounds and one chain add
// end of message pads byte by byte and compresses once or twice
// the four digest words then leave one per transaction, honoring i_stall
// reset restores the initial vector and clears the length; no clearing pass
// ----------------------------------------------------------------------------
module md5_message_digest_top import md5_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    t_state r_state, n_state;
    logic [63:0] r_count, n_count;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_final, n_final;
    logic        r_two, n_two;
    logic        r_pad, n_pad;
    logic [1:0]  r_widx, n_widx;
    logic [31:0] r_w [16];
    logic [31:0] r_wsh;
    logic [31:0] chain [4];
    logic        we;
    logic [BLK_AW-1:0] addr;
    logic [7:0]  wdata, rdata;
    logic [63:0] bits;
    logic        reinit;
    t_core_ctl   ctl;

    md5_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    md5_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_reinit(reinit),
        .i_w(r_w[round_g(ctl.round)]), .o_chain(chain)
    );

    assign bits = {r_count[60:0], 3'b000};
    assign o_valid = (r_state == S_OUT);
    assign o_digest_word = chain[r_widx];
    assign o_word_index = r_widx;
    assign o_last_word = (r_widx == 2'd3);
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cnt = r_cnt;
        n_final = r_final;
        n_two = r_two;
        n_pad = r_pad;
        n_widx = r_widx;
        we = 1'b0;
        addr = r_count[BLK_AW-1:0];
        wdata = i_data_byte;
        reinit = 1'b0;
        ctl = '{start: 1'b0, done: 1'b0, round: r_cnt[5:0]};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_byte_valid) begin
                        we = 1'b1;
                        n_count = r_count + 64'd1;
                    end
                    n_final = i_end_of_message;
                    n_cnt = '0;
                    if (i_byte_valid && r_count[5:0] == 6'd63) begin
                        n_state = S_LOAD;
                        n_two = 1'b0;
                        // full block with end of message still needs a pad block
                        n_pad = i_end_of_message;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                        n_two = 1'b1;
                    end
                end
            end
            S_PAD: begin
                // pad byte at position r_cnt relative to count
                addr = r_cnt[BLK_AW-1:0];
                we = 1'b1;
                if (r_cnt[5:0] == r_count[5:0] && r_two) begin
                    wdata = 8'h80;
                end else if (r_cnt[5:0] >= LEN_POS && !(r_two && r_count[5:0] >= LEN_POS)) begin
                    wdata = bits[8*(r_cnt[2:0]) +: 8];
                end else begin
                    wdata = 8'h00;
                end
                if (r_two && r_cnt[5:0] < r_count[5:0]) begin
                    we = 1'b0;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[5:0] == 6'd63) begin
                    n_cnt = '0;
                    n_state = S_LOAD;
                    // second block needed when marker lands in the length slot
                    n_two = r_two && (r_count[5:0] >= LEN_POS);
                    n_final = !n_two;
                end
            end
            S_LOAD: begin
                // bytes stream out of the ram into the word shift register
                addr = r_cnt[BLK_AW-1:0];
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    n_cnt = '0;
                    ctl.start = 1'b1;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                ctl.done = 1'b1;
                n_cnt = '0;
                if (r_pad) begin
                    n_pad = 1'b0;
                    n_two = 1'b1;
                    n_state = S_PAD;
                end else if (r_two) begin
                    n_two = 1'b0;
                    n_state = S_PAD;
                end else if (r_final) begin
                    n_widx = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                ctl.done = 1'b1;
                if (!i_stall) begin
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        reinit = 1'b1;
                        n_count = '0;
                        n_final = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // chain must hold while outputs stream
        if (r_state == S_OUT && !reinit) begin
            ctl.done = 1'b0;
            ctl.start = 1'b0;
        end
    end

    // second pad pass writes zeros then length; first pass flag r_two marks marker pass
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && r_cnt != 7'd0) begin
            r_wsh <= {rdata, r_wsh[31:8]};
            if (r_cnt[1:0] == 2'd0) begin
                r_w[r_cnt[5:2] - 4'd1] <= {rdata, r_wsh[31:8]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cnt <= '0;
            r_final <= 1'b0;
            r_two <= 1'b0;
            r_pad <= 1'b0;
            r_widx <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cnt <= n_cnt;
            r_final <= n_final;
            r_two <= n_two;
            r_pad <= n_pad;
            r_widx <= n_widx;
        end
    end
endmodule

@@ dv/md5_message_digest_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5 message digest testbench
// streams byte messages of many lengths into the digest block, computes the
// md5 of each message alongside and checks every digest word that comes out
// ----------------------------------------------------------------------------
module md5_message_digest_top_tb;
    import md5_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_byte_txn;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_digest_txn;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_byte_valid = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    md5_message_digest_top DUT (.*);

    always #4 i_clk = ~i_clk;

    t_byte_txn   pending_bytes[$];
    t_digest_txn expected_digests[$];
    logic [31:0] chain[4];
    logic [7:0]  blk[64];
    logic [63:0] msg_len;
    int          mismatches = 0;
    int          digests_seen = 0;
    int          messages = 0;
    int          bytes_sent = 0;
    bit          stim_done = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    task automatic md5_compress();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, t;
        int          g, ph, sh;
        int          rot_tab[16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                     4, 11, 16, 23, 6, 10, 15, 21};
        logic [31:0] kt[64] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int r = 0; r < 64; r++) begin
            ph = r / 16;
            case (ph)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            sh = rot_tab[ph * 4 + r % 4];
            t = d; d = c; c = b;
            b = b + rol(a + f + kt[r] + w[g], sh);
            a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic md5_restart();
        chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D;
        msg_len = '0;
    endtask

    // advances the digest state for one accepted transaction
    task automatic md5_absorb(t_byte_txn tr);
        int          pos;
        logic [63:0] bits;
        t_digest_txn e;
        if (tr.byte_valid) begin
            pos = msg_len[5:0];
            blk[pos] = tr.data_byte;
            msg_len++;
            if (pos == 63) md5_compress();
        end
        if (!tr.end_of_message) return;
        pos = msg_len[5:0];
        bits = msg_len << 3;
        blk[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
            while (pos < 64) blk[pos++] = 8'h00;
            md5_compress();
            pos = 0;
        end
        while (pos < 56) blk[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
        md5_compress();
        for (int k = 0; k < 4; k++) begin
            e.digest_word = chain[k];
            e.word_index = 2'(k);
            e.last_word = (k == 3);
            expected_digests.push_back(e);
        end
        messages++;
        md5_restart();
    endtask

    task automatic queue_message(int len, int mode);
        t_byte_txn tr;
        for (int i = 0; i < len; i++) begin
            tr.byte_valid = 1'b1;
            tr.end_of_message = 1'b0;
            case (mode)
                0: tr.data_byte = 8'h00;
                1: tr.data_byte = 8'hff;
                default: tr.data_byte = 8'($urandom);
            endcase
            if (i == len - 1 && $urandom_range(0, 1)) tr.end_of_message = 1'b1;
            pending_bytes.push_back(tr);
            if ($urandom_range(0, 15) == 0) begin
                tr = '{data_byte: 8'($urandom), byte_valid: 1'b0, end_of_message: 1'b0};
                pending_bytes.push_back(tr);
            end
        end
        if (len == 0 || !pending_bytes[$].end_of_message) begin
            tr = '{data_byte: 8'($urandom), byte_valid: 1'b0, end_of_message: 1'b1};
            pending_bytes.push_back(tr);
        end
    endtask

    initial begin
        md5_restart();
        // empty message, short messages, idle items
        pending_bytes.push_back('{8'ha5, 1'b0, 1'b0});
        queue_message(0, 2);
        queue_message(1, 0);
        queue_message(3, 1);
        queue_message(1, 2);
        queue_message(2, 2);
        queue_message(5, 2);
        queue_message(8, 1);
        // random messages, short ones and lengths around block and padding boundaries
        while (pending_bytes.size() < 370) begin
            case ($urandom_range(0, 5))
                0: queue_message($urandom_range(55, 57), 2);
                1: queue_message($urandom_range(63, 65), 2);
                2: queue_message($urandom_range(119, 129), 2);
                default: queue_message($urandom_range(0, 20), 2);
            endcase
        end
        stim_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (in_gap > 0 || pending_bytes.size() == 0) begin
                i_valid <= 1'b0;
                if (in_gap > 0) in_gap <= in_gap - 1;
            end else begin
                t_byte_txn tr;
                tr = pending_bytes.pop_front();
                i_valid <= 1'b1;
                i_data_byte <= tr.data_byte;
                i_byte_valid <= tr.byte_valid;
                i_end_of_message <= tr.end_of_message;
                in_gap <= pick_gap();
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                md5_absorb('{i_data_byte, i_byte_valid, i_end_of_message});
                if (i_byte_valid) bytes_sent++;
            end
            if (o_valid && !i_stall) begin
                t_digest_txn got, e;
                got = '{o_digest_word, o_word_index, o_last_word};
                digests_seen++;
                if (expected_digests.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest transaction %h", got);
                end else begin
                    e = expected_digests.pop_front();
                    if (got !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected word %h idx %0d last %0b, got %h idx %0d last %0b",
                                     e.digest_word, e.word_index, e.last_word,
                                     got.digest_word, got.word_index, got.last_word);
                    end
                end
            end
            if (out_gap > 0) begin
                i_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_bytes.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (expected_digests.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d messages, %0d bytes, %0d digest words checked",
                 messages, bytes_sent, digests_seen);
        if (mismatches == 0 && expected_digests.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule
